// File: hdl/iqbd_pkg.sv
// ----------------------------------------------------------------------------
// iqbd_pkg
// Shared constants, tables and types of the IQ baseband demodulator.
// ----------------------------------------------------------------------------
package iqbd_pkg;

  localparam int TAPS         = 15;
  localparam int TAP_AW       = $clog2(TAPS);
  localparam int SPS          = 8;
  localparam int PH_W         = $clog2(SPS);
  localparam int CAR_W        = 5;
  localparam int CARRIER_STEP = 4;
  localparam int SMP_W        = 8;
  localparam int MIX_W        = 2 * SMP_W;
  localparam int MIX_SHIFT    = 7;
  localparam int COEF_W       = 15;
  localparam int PROD_W       = SMP_W + COEF_W;
  localparam int ACC_W        = 24;
  localparam int FIR_SHIFT    = 15;
  localparam int SAT_MAX      = 127;
  localparam int SLICE_TH     = 32;
  localparam int MODE_W       = 2;
  localparam int SYM_W        = 4;
  localparam int NBITS_W      = 3;
  localparam int ERR_W        = 3;
  localparam int CNT_W        = 32;
  localparam int PN_W         = 7;
  localparam int OUT_TDATA_W  = 96;

  localparam logic [MODE_W-1:0] MODE_BPSK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QPSK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  localparam logic [PN_W-1:0] PN_SEED = 7'd1;

  localparam logic signed [SMP_W-1:0] COS_TABLE [0:31] = '{
     8'sd127,  8'sd117,  8'sd90,   8'sd49,   8'sd0,   -8'sd49,  -8'sd90,  -8'sd117,
    -8'sd127, -8'sd117, -8'sd90,  -8'sd49,   8'sd0,    8'sd49,   8'sd90,   8'sd117,
     8'sd127,  8'sd117,  8'sd90,   8'sd49,   8'sd0,   -8'sd49,  -8'sd90,  -8'sd117,
    -8'sd127, -8'sd117, -8'sd90,  -8'sd49,   8'sd0,    8'sd49,   8'sd90,   8'sd117
  };

  // Negated sine, so the Q arm is a plain multiply
  localparam logic signed [SMP_W-1:0] NSIN_TABLE [0:31] = '{
     8'sd0,   -8'sd49,  -8'sd90,  -8'sd117, -8'sd127, -8'sd117, -8'sd90,  -8'sd49,
     8'sd0,    8'sd49,   8'sd90,   8'sd117,  8'sd127,  8'sd117,  8'sd90,   8'sd49,
     8'sd0,   -8'sd49,  -8'sd90,  -8'sd117, -8'sd127, -8'sd117, -8'sd90,  -8'sd49,
     8'sd0,    8'sd49,   8'sd90,   8'sd117,  8'sd127,  8'sd117,  8'sd90,   8'sd49
  };

  localparam logic signed [COEF_W-1:0] COEF_TABLE [0:TAPS-1] = '{
    -15'sd512, -15'sd768, -15'sd384, 15'sd768, 15'sd3072, 15'sd6144, 15'sd9216,
     15'sd10240,
     15'sd9216, 15'sd6144, 15'sd3072, 15'sd768, -15'sd384, -15'sd768, -15'sd512
  };

  typedef struct packed {
    logic                    done;
    logic signed [SMP_W-1:0] fi;
    logic signed [SMP_W-1:0] fq;
  } fir_res_t;

  typedef struct packed {
    logic decide;
    logic clear;
  } ber_cmd_t;

endpackage

// File: hdl/iq_baseband_demodulator.sv
// ----------------------------------------------------------------------------
// iq_baseband_demodulator
// Downconverter, 15-tap FIR, QAM slicer and PN7 bit error counter.
// ----------------------------------------------------------------------------
// Each sample transaction (tuser 0) is mixed with the carrier, written into
// the filter's delay-line memory and filtered by one multiply-accumulate that
// walks the 15 taps out of that memory. No new transaction is accepted
// until the filter result is ready, and after the eighth sample of a symbol
// not until the previous result has been taken from the output. A clear
// transaction (tuser 1) resets the bit counters and the PN7 seed. Every eighth
// sample yields one result transaction. The user must write modulation_mode
// through cfg_wen/cfg_wdata only while the block is idle; the block does not enforce it.
module iq_baseband_demodulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [iqbd_pkg::MODE_W-1:0]         cfg_wdata,     // modulation_mode
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [iqbd_pkg::SMP_W-1:0]          s_axis_tdata,  // adc_sample
  input  logic                                s_axis_tuser,  // cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // symbol_bits[3:0], bit_count[6:4], filtered_i[14:7], filtered_q[22:15],
  // symbol_errors[25:23], total_bits_seen[57:26], total_bit_errors[89:58]
  output logic [iqbd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_FIR  = 2'd2;
  localparam logic [1:0] ST_DEC  = 2'd3;

  localparam logic [iqbd_pkg::PH_W-1:0] PH_LAST = iqbd_pkg::PH_W'(iqbd_pkg::SPS - 1);

  logic [1:0]                        state;
  logic [1:0]                        state_next;
  logic [iqbd_pkg::PH_W-1:0]         sample_phase;
  logic [iqbd_pkg::MODE_W-1:0]       mode;
  logic                              accept;
  logic                              mix_en;
  logic                              fir_start;
  logic                              slot_free;
  logic signed [iqbd_pkg::SMP_W-1:0] mi;
  logic signed [iqbd_pkg::SMP_W-1:0] mq;
  iqbd_pkg::fir_res_t                fir_res;
  iqbd_pkg::ber_cmd_t                ber_cmd;

  assign s_axis_tready  = (state == ST_IDLE);
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign mix_en         = accept && !s_axis_tuser;
  assign fir_start      = (state == ST_MIX);
  assign ber_cmd        = '{decide: (state == ST_DEC) && slot_free,
                            clear:  accept && s_axis_tuser};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (mix_en) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        state_next = ST_FIR;
      end
      ST_FIR: begin
        if (fir_res.done) begin
          state_next = (sample_phase == PH_LAST) ? ST_DEC : ST_IDLE;
        end
      end
      ST_DEC: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_phase <= '0;
      mode         <= iqbd_pkg::MODE_RESET;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        mode <= cfg_wdata;
      end
      // advance the symbol phase once the filter output is ready
      if (state == ST_FIR && fir_res.done) begin
        sample_phase <= (sample_phase == PH_LAST) ? '0 : sample_phase + 1'b1;
      end
    end
  end

  iqbd_mixer u_mixer (
    .clk    (clk),
    .rst    (rst),
    .en     (mix_en),
    .sample ($signed(s_axis_tdata)),
    .mi     (mi),
    .mq     (mq)
  );

  iqbd_fir u_fir (
    .clk   (clk),
    .rst   (rst),
    .start (fir_start),
    .mi    (mi),
    .mq    (mq),
    .res   (fir_res)
  );

  iqbd_ber u_ber (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ber_cmd),
    .mode          (mode),
    .fi            (fir_res.fi),
    .fq            (fir_res.fq),
    .slot_free     (slot_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hdl/iqbd_mixer.sv
// ----------------------------------------------------------------------------
// iqbd_mixer
// Carrier NCO and complex mixer: sample times cos and -sin, floor to Q0.
// ----------------------------------------------------------------------------
module iqbd_mixer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic signed [iqbd_pkg::SMP_W-1:0] sample,
  output logic signed [iqbd_pkg::SMP_W-1:0] mi,
  output logic signed [iqbd_pkg::SMP_W-1:0] mq
);

  logic [iqbd_pkg::CAR_W-1:0]        carrier_phase;
  logic signed [iqbd_pkg::MIX_W-1:0] prod_i;
  logic signed [iqbd_pkg::MIX_W-1:0] prod_q;

  assign prod_i = sample * iqbd_pkg::COS_TABLE[carrier_phase];
  assign prod_q = sample * iqbd_pkg::NSIN_TABLE[carrier_phase];

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
    end else if (en) begin
      carrier_phase <= carrier_phase + iqbd_pkg::CAR_W'(iqbd_pkg::CARRIER_STEP);
    end
  end

  // arithmetic shift is floor division
  always_ff @(posedge clk) begin
    if (en) begin
      mi <= iqbd_pkg::SMP_W'(prod_i >>> iqbd_pkg::MIX_SHIFT);
      mq <= iqbd_pkg::SMP_W'(prod_q >>> iqbd_pkg::MIX_SHIFT);
    end
  end

endmodule

// File: hdl/iqbd_fir.sv
// ----------------------------------------------------------------------------
// iqbd_fir
// Circular delay line in a one-port-read memory, walked by a pipelined
// multiply-accumulate for both arms, then floor shift and saturation.
// ----------------------------------------------------------------------------
module iqbd_fir (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [iqbd_pkg::SMP_W-1:0] mi,
  input  logic signed [iqbd_pkg::SMP_W-1:0] mq,
  output iqbd_pkg::fir_res_t                res
);

  localparam int ENT_W = 2 * iqbd_pkg::SMP_W;
  localparam logic [iqbd_pkg::TAP_AW-1:0] LAST = iqbd_pkg::TAP_AW'(iqbd_pkg::TAPS - 1);
  localparam logic signed [iqbd_pkg::ACC_W-1:0] SAT_HI =
    iqbd_pkg::ACC_W'(iqbd_pkg::SAT_MAX);
  localparam logic signed [iqbd_pkg::ACC_W-1:0] SAT_LO = -SAT_HI;

  logic [ENT_W-1:0] mem [0:iqbd_pkg::TAPS-1];

  logic [iqbd_pkg::TAPS-1:0]     vld;
  logic [iqbd_pkg::TAP_AW-1:0]   ws;
  logic [iqbd_pkg::TAP_AW-1:0]   ws_inc;
  logic [iqbd_pkg::TAP_AW-1:0]   rd_addr;
  logic [iqbd_pkg::TAP_AW-1:0]   rd_addr_inc;
  logic [iqbd_pkg::TAP_AW:0]     issue_cnt;
  logic                          issuing;

  logic [ENT_W-1:0]              rd_data;
  logic                          rd_ok;
  logic                          p1_v;
  logic [iqbd_pkg::TAP_AW-1:0]   p1_k;

  logic signed [iqbd_pkg::SMP_W-1:0]  di;
  logic signed [iqbd_pkg::SMP_W-1:0]  dq;
  logic                               p2_v;
  logic                               p2_last;
  logic signed [iqbd_pkg::PROD_W-1:0] prod_i;
  logic signed [iqbd_pkg::PROD_W-1:0] prod_q;

  logic signed [iqbd_pkg::ACC_W-1:0]  acc_i;
  logic signed [iqbd_pkg::ACC_W-1:0]  acc_q;
  logic                               acc_last;

  logic                               res_done;
  logic signed [iqbd_pkg::SMP_W-1:0]  res_fi;
  logic signed [iqbd_pkg::SMP_W-1:0]  res_fq;

  function automatic logic signed [iqbd_pkg::SMP_W-1:0] sat(
    input logic signed [iqbd_pkg::ACC_W-1:0] acc
  );
    logic signed [iqbd_pkg::ACC_W-1:0] v;
    v = acc >>> iqbd_pkg::FIR_SHIFT;
    if (v > SAT_HI) begin
      return iqbd_pkg::SMP_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return iqbd_pkg::SMP_W'(SAT_LO);
    end
    return iqbd_pkg::SMP_W'(v);
  endfunction

  assign ws_inc      = (ws == LAST) ? '0 : ws + 1'b1;
  assign rd_addr_inc = (rd_addr == LAST) ? '0 : rd_addr + 1'b1;
  assign issuing     = (issue_cnt != (iqbd_pkg::TAP_AW + 1)'(iqbd_pkg::TAPS));

  assign res = '{done: res_done, fi: res_fi, fq: res_fq};

  // write newest sample, then read from oldest to newest
  always_ff @(posedge clk) begin
    if (start) begin
      mem[ws] <= {mq, mi};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      ws        <= '0;
      rd_addr   <= '0;
      issue_cnt <= (iqbd_pkg::TAP_AW + 1)'(iqbd_pkg::TAPS);
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      acc_last  <= 1'b0;
      res_done  <= 1'b0;
    end else begin
      if (start) begin
        vld[ws]   <= 1'b1;
        ws        <= ws_inc;
        rd_addr   <= ws_inc;
        issue_cnt <= '0;
      end else if (issuing) begin
        rd_addr   <= rd_addr_inc;
        issue_cnt <= issue_cnt + 1'b1;
      end
      p1_v     <= issuing && !start;
      p2_v     <= p1_v;
      acc_last <= p2_v && p2_last;
      res_done <= acc_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok   <= vld[rd_addr];
    p1_k    <= issue_cnt[iqbd_pkg::TAP_AW-1:0];
  end

  // unwritten entries read as zero
  assign di = rd_ok ? $signed(rd_data[iqbd_pkg::SMP_W-1:0]) : '0;
  assign dq = rd_ok ? $signed(rd_data[ENT_W-1:iqbd_pkg::SMP_W]) : '0;

  always_ff @(posedge clk) begin
    if (p1_v) begin
      prod_i  <= di * iqbd_pkg::COEF_TABLE[p1_k];
      prod_q  <= dq * iqbd_pkg::COEF_TABLE[p1_k];
      p2_last <= (p1_k == LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (p2_v) begin
      acc_i <= acc_i + iqbd_pkg::ACC_W'(prod_i);
      acc_q <= acc_q + iqbd_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_last) begin
      res_fi <= sat(acc_i);
      res_fq <= sat(acc_q);
    end
  end

endmodule

// File: hdl/iqbd_ber.sv
// ----------------------------------------------------------------------------
// iqbd_ber
// Symbol slicer, PN7 reference checker, BER counters and output register.
// ----------------------------------------------------------------------------
module iqbd_ber (
  input  logic                                   clk,
  input  logic                                   rst,
  input  iqbd_pkg::ber_cmd_t                     cmd,
  input  logic [iqbd_pkg::MODE_W-1:0]            mode,
  input  logic signed [iqbd_pkg::SMP_W-1:0]      fi,
  input  logic signed [iqbd_pkg::SMP_W-1:0]      fq,
  output logic                                   slot_free,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [iqbd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam logic signed [iqbd_pkg::SMP_W-1:0] TH =
    iqbd_pkg::SMP_W'(iqbd_pkg::SLICE_TH);
  localparam int PAD_W = iqbd_pkg::OUT_TDATA_W - iqbd_pkg::SYM_W - iqbd_pkg::NBITS_W
                         - 2 * iqbd_pkg::SMP_W - iqbd_pkg::ERR_W - 2 * iqbd_pkg::CNT_W;

  logic [iqbd_pkg::PN_W-1:0]    lfsr;
  logic [iqbd_pkg::PN_W-1:0]    lfsr_next;
  logic [iqbd_pkg::CNT_W-1:0]   bits_compared;
  logic [iqbd_pkg::CNT_W-1:0]   bits_compared_next;
  logic [iqbd_pkg::CNT_W-1:0]   errors_counted;
  logic [iqbd_pkg::CNT_W-1:0]   errors_counted_next;
  logic [iqbd_pkg::SYM_W-1:0]   bits;
  logic [iqbd_pkg::NBITS_W-1:0] nbits;
  logic [iqbd_pkg::ERR_W-1:0]   errs;

  function automatic logic [1:0] slice(input logic signed [iqbd_pkg::SMP_W-1:0] v);
    if (v < -TH) begin
      return 2'b00;
    end else if (v < 0) begin
      return 2'b01;
    end else if (v < TH) begin
      return 2'b11;
    end
    return 2'b10;
  endfunction

  always_comb begin
    unique case (mode)
      iqbd_pkg::MODE_BPSK: begin
        bits  = {3'b000, fi > 0};
        nbits = 3'd1;
      end
      iqbd_pkg::MODE_QPSK: begin
        bits  = {2'b00, fi > 0, fq > 0};
        nbits = 3'd2;
      end
      default: begin
        bits  = {slice(fi), slice(fq)};
        nbits = 3'd4;
      end
    endcase
  end

  // compare LSB first, one PN7 step per valid bit
  always_comb begin
    logic pn_bit;
    lfsr_next = lfsr;
    errs      = '0;
    for (int k = 0; k < iqbd_pkg::SYM_W; k++) begin
      pn_bit = lfsr_next[6] ^ lfsr_next[5];
      if (iqbd_pkg::NBITS_W'(k) < nbits) begin
        lfsr_next = {lfsr_next[iqbd_pkg::PN_W-2:0], pn_bit};
        if (bits[k] != pn_bit) begin
          errs = errs + 1'b1;
        end
      end
    end
    bits_compared_next  = bits_compared + iqbd_pkg::CNT_W'(nbits);
    errors_counted_next = errors_counted + iqbd_pkg::CNT_W'(errs);
  end

  assign slot_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr           <= iqbd_pkg::PN_SEED;
      bits_compared  <= '0;
      errors_counted <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        lfsr           <= iqbd_pkg::PN_SEED;
        bits_compared  <= '0;
        errors_counted <= '0;
      end else if (cmd.decide) begin
        lfsr           <= lfsr_next;
        bits_compared  <= bits_compared_next;
        errors_counted <= errors_counted_next;
      end
      if (cmd.decide) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      m_axis_tdata <= {PAD_W'(0), errors_counted_next, bits_compared_next, errs,
                       fq, fi, nbits, bits};
    end
  end

endmodule
